>>> rtl/rot3_pkg.sv
// Shared constants and types for the 3d vector / tensor rotation block.
// Used by every module under rtl/; has no dependencies of its own.
package rot3_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int COEF_FRAC_DEF  = 16;

    localparam int ENTRY_W   = 18;              // one rotation entry, signed
    localparam int ROW_W     = 3 * ENTRY_W;
    localparam int N_COMP    = 9;
    localparam int N_LANE    = 9;
    localparam int N_CMD     = 3;
    localparam int TERM_LIM_LOG = 58;           // terms clamp to +-2^58
    localparam int TERM_W    = TERM_LIM_LOG + 2;
    localparam int PART_W    = TERM_W + 2;
    localparam int ACC_W     = 64;
    localparam int CFG_ADDR_W = 2;

    localparam logic [ROW_W-1:0] ROW0_RST = ROW_W'(64'd65536);
    localparam logic [ROW_W-1:0] ROW1_RST = ROW_W'(64'd17179869184);
    localparam logic [ROW_W-1:0] ROW2_RST = ROW_W'(64'd4503599627370496);

    localparam logic [CFG_ADDR_W-1:0] REG_ROW0 = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ROW1 = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_ROW2 = 2'd2;

    // cycles for the coefficient table to follow a register write
    localparam logic [1:0] SETTLE = 2'd2;

    typedef enum logic [1:0] {
        CMD_VEC  = 2'd0,
        CMD_SYM  = 2'd1,
        CMD_FULL = 2'd2
    } cmd_t;

    // per-stage load enables handed to each lane
    typedef struct packed {
        logic mul;
        logic term;
        logic part;
        logic res;
    } lane_en_t;

endpackage

>>> rtl/rot3_coef.sv
// Rotation registers and the coefficient table derived from them.
// Depends on rot3_pkg; the table is rebuilt after a register write.
module rot3_coef
    import rot3_pkg::*;
#(
    parameter int COEF_FRAC = COEF_FRAC_DEF,
    localparam int COEF_W = 2 * ENTRY_W + 2 - COEF_FRAC
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]          cfg_addr,
    input  logic [ROW_W-1:0]               cfg_wdata,
    output logic signed [COEF_W-1:0]       coef_tab [N_CMD][N_LANE][N_COMP]
);

    localparam int PW   = 2 * ENTRY_W;
    localparam int PS_W = PW + 1;
    localparam int SQ_W = COEF_FRAC + 2;
    localparam logic [63:0] SQRT2_Q =
        (64'd6074001000 + (64'd1 << (31 - COEF_FRAC))) >> (32 - COEF_FRAC);

    logic [ROW_W-1:0]          row_reg [3];
    logic signed [ENTRY_W-1:0] ent [9];
    logic signed [PW-1:0]      prod_reg [9][9];
    logic signed [COEF_W-1:0]  tab_next [N_CMD][N_LANE][N_COMP];

    function automatic logic signed [COEF_W-1:0] fl2(input logic signed [PW-1:0] v1,
                                                      input logic signed [PW-1:0] v2);
        logic signed [PS_W-1:0] s;
        s = PS_W'(v1) + PS_W'(v2);
        s = s >>> COEF_FRAC;
        return s[COEF_W-1:0];
    endfunction

    function automatic logic signed [COEF_W-1:0] fl(input logic signed [PW-1:0] v);
        return fl2(v, '0);
    endfunction

    function automatic logic signed [COEF_W-1:0] sq2(input logic signed [COEF_W-1:0] c);
        logic signed [SQ_W-1:0]        k;
        logic signed [COEF_W+SQ_W-1:0] p;
        k = SQRT2_Q[SQ_W-1:0];
        p = c * k;
        p = p >>> COEF_FRAC;
        return p[COEF_W-1:0];
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg[0] <= ROW0_RST;
            row_reg[1] <= ROW1_RST;
            row_reg[2] <= ROW2_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_ROW0: row_reg[0] <= cfg_wdata;
                REG_ROW1: row_reg[1] <= cfg_wdata;
                REG_ROW2: row_reg[2] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                ent[r*3+c] = row_reg[r][c*ENTRY_W +: ENTRY_W];
            end
        end
    end

    // all entry products, index r*3+c
    always_ff @(posedge aclk) begin
        for (int i = 0; i < 9; i++) begin
            for (int j = 0; j < 9; j++) begin
                prod_reg[i][j] <= ent[i] * ent[j];
            end
        end
    end

    always_comb begin
        int a, b, p, q;
        tab_next = '{default: '0};
        for (int j = 0; j < 3; j++) begin
            for (int k = 0; k < 3; k++) begin
                tab_next[CMD_VEC][j][k] = COEF_W'(ent[j*3+k]);
            end
            // diagonal lanes of both tensor forms
            tab_next[CMD_SYM][j][0]  = fl(prod_reg[j][j]);
            tab_next[CMD_SYM][j][1]  = fl(prod_reg[3+j][3+j]);
            tab_next[CMD_SYM][j][2]  = fl(prod_reg[6+j][6+j]);
            tab_next[CMD_SYM][j][3]  = sq2(fl(prod_reg[j][3+j]));
            tab_next[CMD_SYM][j][4]  = sq2(fl(prod_reg[j][6+j]));
            tab_next[CMD_SYM][j][5]  = sq2(fl(prod_reg[3+j][6+j]));
            tab_next[CMD_FULL][j][0] = fl(prod_reg[j][j]);
            tab_next[CMD_FULL][j][1] = fl(prod_reg[3+j][3+j]);
            tab_next[CMD_FULL][j][2] = fl(prod_reg[6+j][6+j]);
            tab_next[CMD_FULL][j][3] = fl(prod_reg[j][3+j]);
            tab_next[CMD_FULL][j][4] = fl(prod_reg[j][3+j]);
            tab_next[CMD_FULL][j][5] = fl(prod_reg[j][6+j]);
            tab_next[CMD_FULL][j][6] = fl(prod_reg[j][6+j]);
            tab_next[CMD_FULL][j][7] = fl(prod_reg[3+j][6+j]);
            tab_next[CMD_FULL][j][8] = fl(prod_reg[3+j][6+j]);
        end
        for (int j = 0; j < 3; j++) begin
            a = (j == 2) ? 1 : 0;
            b = (j == 0) ? 1 : 2;
            tab_next[CMD_SYM][3+j][0] = sq2(fl(prod_reg[a][b]));
            tab_next[CMD_SYM][3+j][1] = sq2(fl(prod_reg[3+a][3+b]));
            tab_next[CMD_SYM][3+j][2] = sq2(fl(prod_reg[6+a][6+b]));
            tab_next[CMD_SYM][3+j][3] = fl2(prod_reg[a][3+b], prod_reg[b][3+a]);
            tab_next[CMD_SYM][3+j][4] = fl2(prod_reg[a][6+b], prod_reg[b][6+a]);
            tab_next[CMD_SYM][3+j][5] = fl2(prod_reg[3+a][6+b], prod_reg[3+b][6+a]);
        end
        for (int j = 0; j < 6; j++) begin
            a = (j / 2 == 2) ? 1 : 0;
            b = (j / 2 == 0) ? 1 : 2;
            p = (j % 2 == 1) ? a : b;
            q = (j % 2 == 1) ? b : a;
            tab_next[CMD_FULL][3+j][8] = fl(prod_reg[3+p][6+q]);
            tab_next[CMD_FULL][3+j][7] = fl(prod_reg[3+q][6+p]);
            tab_next[CMD_FULL][3+j][6] = fl(prod_reg[p][6+q]);
            tab_next[CMD_FULL][3+j][5] = fl(prod_reg[q][6+p]);
            tab_next[CMD_FULL][3+j][4] = fl(prod_reg[p][3+q]);
            tab_next[CMD_FULL][3+j][3] = fl(prod_reg[q][3+p]);
            tab_next[CMD_FULL][3+j][2] = fl(prod_reg[6+a][6+b]);
            tab_next[CMD_FULL][3+j][1] = fl(prod_reg[3+a][3+b]);
            tab_next[CMD_FULL][3+j][0] = fl(prod_reg[a][b]);
        end
    end

    always_ff @(posedge aclk) begin
        coef_tab <= tab_next;
    end

endmodule

>>> rtl/rot3_lane.sv
// One output lane: nine coefficient products, floor and clamp, sum, saturate.
// Depends on rot3_pkg; stage loads come from the top level as a lane_en_t.
module rot3_lane
    import rot3_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int COEF_FRAC  = COEF_FRAC_DEF,
    localparam int COEF_W = 2 * ENTRY_W + 2 - COEF_FRAC
) (
    input  logic                          aclk,
    input  lane_en_t                      en,
    input  logic signed [DATA_WIDTH-1:0]  x [N_COMP],
    input  logic signed [COEF_W-1:0]      coef [N_COMP],
    output logic signed [DATA_WIDTH-1:0]  res,
    output logic                          sat
);

    localparam int MUL_W  = COEF_W + DATA_WIDTH;
    localparam int TS_W   = MUL_W - COEF_FRAC;
    localparam int WIDE_W = (TS_W > TERM_W) ? TS_W : TERM_W;
    localparam logic signed [WIDE_W-1:0] LIM_P = WIDE_W'(1) << TERM_LIM_LOG;
    localparam logic signed [WIDE_W-1:0] LIM_N = -LIM_P;
    localparam logic signed [ACC_W-1:0] SAT_HI = (ACC_W'(1) << (DATA_WIDTH - 1)) - 1;
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - 1;

    logic signed [MUL_W-1:0]      mul_reg  [N_COMP];
    logic signed [TERM_W-1:0]     term_reg [N_COMP];
    logic signed [TERM_W-1:0]     term_next [N_COMP];
    logic signed [PART_W-1:0]     part_reg [3];
    logic signed [ACC_W-1:0]      acc;
    logic signed [DATA_WIDTH-1:0] res_reg;
    logic                         sat_reg;

    always_ff @(posedge aclk) begin
        if (en.mul) begin
            for (int k = 0; k < N_COMP; k++) begin
                mul_reg[k] <= coef[k] * x[k];
            end
        end
    end

    // floor by the coefficient scale, then clamp each term
    always_comb begin
        logic signed [WIDE_W-1:0] t;
        for (int k = 0; k < N_COMP; k++) begin
            t = WIDE_W'($signed(mul_reg[k][MUL_W-1:COEF_FRAC]));
            if (t > LIM_P) begin
                t = LIM_P;
            end else if (t < LIM_N) begin
                t = LIM_N;
            end
            term_next[k] = t[TERM_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en.term) begin
            term_reg <= term_next;
        end
        if (en.part) begin
            for (int g = 0; g < 3; g++) begin
                part_reg[g] <= PART_W'(term_reg[3*g]) + PART_W'(term_reg[3*g+1])
                             + PART_W'(term_reg[3*g+2]);
            end
        end
    end

    assign acc = ACC_W'(part_reg[0]) + ACC_W'(part_reg[1]) + ACC_W'(part_reg[2]);

    always_ff @(posedge aclk) begin
        if (en.res) begin
            if (acc > SAT_HI) begin
                res_reg <= SAT_HI[DATA_WIDTH-1:0];
                sat_reg <= 1'b1;
            end else if (acc < SAT_LO) begin
                res_reg <= SAT_LO[DATA_WIDTH-1:0];
                sat_reg <= 1'b1;
            end else begin
                res_reg <= acc[DATA_WIDTH-1:0];
                sat_reg <= 1'b0;
            end
        end
    end

    assign res = res_reg;
    assign sat = sat_reg;

endmodule

>>> rtl/rot3_merge.sv
// Output register: gathers the nine lane results and merges their clip flags.
// Depends on rot3_pkg.
module rot3_merge
    import rot3_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          load,
    input  logic signed [DATA_WIDTH-1:0]  lane_res [N_LANE],
    input  logic                          lane_sat [N_LANE],
    output logic signed [DATA_WIDTH-1:0]  out_res [N_LANE],
    output logic                          out_sat
);

    logic signed [DATA_WIDTH-1:0] res_reg [N_LANE];
    logic                         sat_reg;
    logic                         sat_any;

    always_comb begin
        sat_any = 1'b0;
        for (int l = 0; l < N_LANE; l++) begin
            sat_any = sat_any | lane_sat[l];
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= lane_res;
            sat_reg <= sat_any;
        end
    end

    assign out_res = res_reg;
    assign out_sat = sat_reg;

endmodule

>>> rtl/rotate_3d_vector_tensor.sv
// Rotation of a 3-vector, a Mandel symmetric tensor or a full 3x3 tensor.
// Input channel s_*: cmd selects the form, comp0..comp8 carry the item
// (signed Q16.16 at default width). Result channel m_*: res0..res8 and the
// saturated flag; components a form does not produce come out zero.
// The configuration port writes the three packed rotation rows; a write
// holds s_ready low while the coefficient table is rebuilt from entry
// products. The accepting edge loads the input register; then come the
// coefficient products, floor and clamp, partial sums, final sum with
// saturation and the output register, whose load raises m_valid. Nine
// lanes of nine multipliers each run side by side, so the block takes one
// item per cycle while the receiver does not stall and no write settles.
// When the receiver stalls, items stay in the pipeline stages and the
// bubbles ahead of the stall are filled before s_ready drops.
// Reset loads the identity rotation and empties the pipeline.
module rotate_3d_vector_tensor
    import rot3_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int COEF_FRAC  = COEF_FRAC_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]         cfg_addr,
    input  logic [ROW_W-1:0]              cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_cmd,
    input  logic signed [DATA_WIDTH-1:0]  s_comp0,
    input  logic signed [DATA_WIDTH-1:0]  s_comp1,
    input  logic signed [DATA_WIDTH-1:0]  s_comp2,
    input  logic signed [DATA_WIDTH-1:0]  s_comp3,
    input  logic signed [DATA_WIDTH-1:0]  s_comp4,
    input  logic signed [DATA_WIDTH-1:0]  s_comp5,
    input  logic signed [DATA_WIDTH-1:0]  s_comp6,
    input  logic signed [DATA_WIDTH-1:0]  s_comp7,
    input  logic signed [DATA_WIDTH-1:0]  s_comp8,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [DATA_WIDTH-1:0]  m_res0,
    output logic signed [DATA_WIDTH-1:0]  m_res1,
    output logic signed [DATA_WIDTH-1:0]  m_res2,
    output logic signed [DATA_WIDTH-1:0]  m_res3,
    output logic signed [DATA_WIDTH-1:0]  m_res4,
    output logic signed [DATA_WIDTH-1:0]  m_res5,
    output logic signed [DATA_WIDTH-1:0]  m_res6,
    output logic signed [DATA_WIDTH-1:0]  m_res7,
    output logic signed [DATA_WIDTH-1:0]  m_res8,
    output logic                          m_saturated
);

    localparam int COEF_W = 2 * ENTRY_W + 2 - COEF_FRAC;

    logic signed [COEF_W-1:0]     coef_tab [N_CMD][N_LANE][N_COMP];
    logic signed [COEF_W-1:0]     coef_sel [N_LANE][N_COMP];
    logic signed [DATA_WIDTH-1:0] x_reg [N_COMP];
    logic [1:0]                   cmd_reg;
    logic [1:0]                   settle_reg, settle_next;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, m_valid_reg;
    logic ld1, ld2, ld3, ld4, ld5, ld_out;
    lane_en_t                     en;
    logic signed [DATA_WIDTH-1:0] lane_res [N_LANE];
    logic                         lane_sat [N_LANE];
    logic signed [DATA_WIDTH-1:0] out_res [N_LANE];

    rot3_coef #(
        .COEF_FRAC (COEF_FRAC)
    ) u_coef (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .coef_tab  (coef_tab)
    );

    // stage loads: a stage takes new data when empty or when it moves on
    assign ld_out = !m_valid_reg || m_ready;
    assign ld5    = !v5_reg || ld_out;
    assign ld4    = !v4_reg || ld5;
    assign ld3    = !v3_reg || ld4;
    assign ld2    = !v2_reg || ld3;
    assign ld1    = !v1_reg || ld2;
    assign s_ready = ld1 && (settle_reg == '0);

    assign en.mul  = ld2;
    assign en.term = ld3;
    assign en.part = ld4;
    assign en.res  = ld5;

    always_comb begin
        settle_next = settle_reg;
        if (cfg_wr_en) begin
            settle_next = SETTLE;
        end else if (settle_reg != '0) begin
            settle_next = settle_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            settle_reg  <= SETTLE;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            v5_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            settle_reg <= settle_next;
            if (ld1)    v1_reg      <= s_valid && s_ready;
            if (ld2)    v2_reg      <= v1_reg;
            if (ld3)    v3_reg      <= v2_reg;
            if (ld4)    v4_reg      <= v3_reg;
            if (ld5)    v5_reg      <= v4_reg;
            if (ld_out) m_valid_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld1) begin
            cmd_reg  <= s_cmd;
            x_reg[0] <= s_comp0;
            x_reg[1] <= s_comp1;
            x_reg[2] <= s_comp2;
            x_reg[3] <= s_comp3;
            x_reg[4] <= s_comp4;
            x_reg[5] <= s_comp5;
            x_reg[6] <= s_comp6;
            x_reg[7] <= s_comp7;
            x_reg[8] <= s_comp8;
        end
    end

    // undefined command picks an all-zero coefficient set
    always_comb begin
        coef_sel = '{default: '0};
        case (cmd_reg)
            CMD_VEC:  coef_sel = coef_tab[CMD_VEC];
            CMD_SYM:  coef_sel = coef_tab[CMD_SYM];
            CMD_FULL: coef_sel = coef_tab[CMD_FULL];
            default:  coef_sel = '{default: '0};
        endcase
    end

    for (genvar l = 0; l < N_LANE; l++) begin : g_lane
        rot3_lane #(
            .DATA_WIDTH (DATA_WIDTH),
            .COEF_FRAC  (COEF_FRAC)
        ) u_lane (
            .aclk (aclk),
            .en   (en),
            .x    (x_reg),
            .coef (coef_sel[l]),
            .res  (lane_res[l]),
            .sat  (lane_sat[l])
        );
    end

    rot3_merge #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_merge (
        .aclk     (aclk),
        .load     (ld_out),
        .lane_res (lane_res),
        .lane_sat (lane_sat),
        .out_res  (out_res),
        .out_sat  (m_saturated)
    );

    assign m_valid = m_valid_reg;
    assign m_res0  = out_res[0];
    assign m_res1  = out_res[1];
    assign m_res2  = out_res[2];
    assign m_res3  = out_res[3];
    assign m_res4  = out_res[4];
    assign m_res5  = out_res[5];
    assign m_res6  = out_res[6];
    assign m_res7  = out_res[7];
    assign m_res8  = out_res[8];

    a_no_item_after_cfg: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en |=> !(s_valid && s_ready))
        else $error("item accepted while coefficient table rebuilds");

    a_out_from_stage5: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(v5_reg))
        else $error("result appeared without a finished item");

    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready && v1_reg && v2_reg && v3_reg && v4_reg && v5_reg)
        |-> !s_ready)
        else $error("input accepted into a full stalled pipeline");

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for rotate_3d_vector_tensor: directed table, then random
// items over several rotation settings. Depends on rtl/rot3_pkg.sv and the block.
module tb;
    import rot3_pkg::*;

    localparam logic [1:0] CMD_NONE = 2'd3;
    localparam longint SQRT2_Q = (64'd6074001000 + (64'd1 << 15)) >> 16;
    localparam longint TERM_MAX = 64'sd1 << 58;
    localparam logic [31:0] WMAX = 32'h7fff_ffff;
    localparam logic [31:0] WMIN = 32'h8000_0000;
    localparam int N_PHASES = 10;
    localparam int PHASE_ITEMS = 94;

    typedef logic signed [31:0] word_t;
    typedef struct {
        word_t res[9];
        bit    sat;
    } rotated_t;
    typedef struct {
        logic [1:0] cmd;
        word_t      comp[9];
        bit         typed;
        word_t      res[9];
    } dir_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = REG_ROW0;
    logic [ROW_W-1:0]      cfg_wdata = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [1:0]            s_cmd = CMD_VEC;
    word_t s_comp0 = 0, s_comp1 = 0, s_comp2 = 0, s_comp3 = 0, s_comp4 = 0;
    word_t s_comp5 = 0, s_comp6 = 0, s_comp7 = 0, s_comp8 = 0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    word_t m_res0, m_res1, m_res2, m_res3, m_res4, m_res5, m_res6, m_res7, m_res8;
    logic                  m_saturated;

    logic [ROW_W-1:0] rot_rows[3];
    longint           mtx[3][3];
    rotated_t         rotated_q[$];
    dir_row_t         dir_tab[12];
    int errors = 0, n_items = 0, n_results = 0, n_sat = 0;
    int cyc = 0, stall_pct = 0;

    rotate_3d_vector_tensor dut (.*);

    always #5 aclk = ~aclk;

    function automatic longint pr(int r1, int c1, int r2, int c2);
        return (mtx[r1][c1] * mtx[r2][c2]) >>> 16;
    endfunction

    function automatic longint pr2(int r1, int c1, int r2, int c2,
                                   int r3, int c3, int r4, int c4);
        return (mtx[r1][c1] * mtx[r2][c2] + mtx[r3][c3] * mtx[r4][c4]) >>> 16;
    endfunction

    function automatic longint sq2(longint c);
        return (c * SQRT2_Q) >>> 16;
    endfunction

    function automatic longint term(longint c, longint x);
        longint t;
        t = (c * x) >>> 16;
        if (t > TERM_MAX) return TERM_MAX;
        if (t < -TERM_MAX) return -TERM_MAX;
        return t;
    endfunction

    function automatic rotated_t rotate_item(logic [1:0] cmd, word_t comp[9]);
        rotated_t o;
        longint x[9], acc[9];
        int pa[3], pb[3];
        int a, b, p, q;
        pa = '{0, 0, 1};
        pb = '{1, 2, 2};
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                mtx[r][c] = longint'($signed(rot_rows[r][ENTRY_W*c +: ENTRY_W]));
        for (int j = 0; j < 9; j++) begin
            x[j] = comp[j];
            acc[j] = 0;
        end
        case (cmd)
            CMD_VEC: begin
                for (int r = 0; r < 3; r++)
                    acc[r] = term(mtx[r][0], x[0]) + term(mtx[r][1], x[1])
                           + term(mtx[r][2], x[2]);
            end
            CMD_SYM: begin
                for (int j = 0; j < 3; j++)
                    acc[j] = term(sq2(pr(1, j, 2, j)), x[5]) + term(sq2(pr(0, j, 2, j)), x[4])
                           + term(sq2(pr(0, j, 1, j)), x[3]) + term(pr(2, j, 2, j), x[2])
                           + term(pr(1, j, 1, j), x[1]) + term(pr(0, j, 0, j), x[0]);
                for (int j = 0; j < 3; j++) begin
                    a = pa[j];
                    b = pb[j];
                    acc[3+j] = term(pr2(1, a, 2, b, 1, b, 2, a), x[5])
                             + term(pr2(0, a, 2, b, 0, b, 2, a), x[4])
                             + term(pr2(0, a, 1, b, 0, b, 1, a), x[3])
                             + term(sq2(pr(2, a, 2, b)), x[2])
                             + term(sq2(pr(1, a, 1, b)), x[1])
                             + term(sq2(pr(0, a, 0, b)), x[0]);
                end
            end
            CMD_FULL: begin
                for (int j = 0; j < 3; j++)
                    acc[j] = term(pr(1, j, 2, j), x[8]) + term(pr(1, j, 2, j), x[7])
                           + term(pr(0, j, 2, j), x[6]) + term(pr(0, j, 2, j), x[5])
                           + term(pr(0, j, 1, j), x[4]) + term(pr(0, j, 1, j), x[3])
                           + term(pr(2, j, 2, j), x[2]) + term(pr(1, j, 1, j), x[1])
                           + term(pr(0, j, 0, j), x[0]);
                // off-diagonal pairs: even j takes (b,a), odd j takes (a,b)
                for (int j = 0; j < 6; j++) begin
                    a = pa[j/2];
                    b = pb[j/2];
                    p = (j % 2) ? a : b;
                    q = (j % 2) ? b : a;
                    acc[3+j] = term(pr(1, p, 2, q), x[8]) + term(pr(1, q, 2, p), x[7])
                             + term(pr(0, p, 2, q), x[6]) + term(pr(0, q, 2, p), x[5])
                             + term(pr(0, p, 1, q), x[4]) + term(pr(0, q, 1, p), x[3])
                             + term(pr(2, a, 2, b), x[2]) + term(pr(1, a, 1, b), x[1])
                             + term(pr(0, a, 0, b), x[0]);
                end
            end
            default: ;
        endcase
        o.sat = 1'b0;
        for (int j = 0; j < 9; j++) begin
            if (acc[j] > 64'sd2147483647) begin
                acc[j] = 64'sd2147483647;
                o.sat = 1'b1;
            end
            if (acc[j] < -64'sd2147483648) begin
                acc[j] = -64'sd2147483648;
                o.sat = 1'b1;
            end
            o.res[j] = acc[j][31:0];
        end
        return o;
    endfunction

    task automatic report(string what, int idx, logic [31:0] got, logic [31:0] want);
        $display("mismatch at result %0d: %s%0d got %h expected %h",
                 n_results, what, idx, got, want);
        errors++;
    endtask

    function automatic logic [ENTRY_W-1:0] rand_entry();
        case ($urandom_range(0, 6))
            0: return 18'h1ffff;
            1: return 18'h20000;
            2: return 18'h10000;
            3: return 18'h30000;
            4: return ENTRY_W'($signed($urandom_range(0, 8191)) - 4096);
            default: return ENTRY_W'($urandom);
        endcase
    endfunction

    function automatic logic [ROW_W-1:0] rand_row();
        return {rand_entry(), rand_entry(), rand_entry()};
    endfunction

    function automatic word_t rand_comp();
        case ($urandom_range(0, 7))
            0: return WMAX;
            1: return WMIN;
            2: return 0;
            3: return -1;
            4: return $signed($urandom_range(0, 1 << 21)) - (1 << 20);
            default: return $urandom;
        endcase
    endfunction

    // sender holds valid until the item goes through, then files its expectation
    task automatic send_item(logic [1:0] cmd, word_t comp[9], bit typed, word_t res[9]);
        rotated_t want;
        s_valid <= 1'b1;
        s_cmd   <= cmd;
        s_comp0 <= comp[0]; s_comp1 <= comp[1]; s_comp2 <= comp[2];
        s_comp3 <= comp[3]; s_comp4 <= comp[4]; s_comp5 <= comp[5];
        s_comp6 <= comp[6]; s_comp7 <= comp[7]; s_comp8 <= comp[8];
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (typed) begin
            want.res = res;
            want.sat = 1'b0;
        end else begin
            want = rotate_item(cmd, comp);
        end
        rotated_q.push_back(want);
        n_items++;
    endtask

    task automatic write_rows(logic [ROW_W-1:0] r0, logic [ROW_W-1:0] r1,
                              logic [ROW_W-1:0] r2);
        logic [ROW_W-1:0] vals[3];
        logic [CFG_ADDR_W-1:0] idx[3];
        vals = '{r0, r1, r2};
        idx  = '{REG_ROW0, REG_ROW1, REG_ROW2};
        s_valid <= 1'b0;
        @(posedge aclk);
        while (rotated_q.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        for (int i = 0; i < 3; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_addr  <= idx[i];
            cfg_wdata <= vals[i];
            rot_rows[i] = vals[i];
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    // receiver: stall rate changes over the run, sometimes no stalls at all
    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (cyc % 50 == 0) begin
            case ($urandom_range(0, 3))
                0: stall_pct <= 0;
                1: stall_pct <= 20;
                2: stall_pct <= 50;
                default: stall_pct <= 85;
            endcase
        end
        m_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge aclk) begin
        rotated_t want;
        word_t got[9];
        if (aresetn && m_valid && m_ready) begin
            got = '{m_res0, m_res1, m_res2, m_res3, m_res4, m_res5, m_res6, m_res7, m_res8};
            if (rotated_q.size() == 0) begin
                $display("unexpected result item %0d", n_results);
                errors++;
            end else begin
                want = rotated_q.pop_front();
                for (int j = 0; j < 9; j++)
                    if (got[j] !== want.res[j]) report("res", j, got[j], want.res[j]);
                if (m_saturated !== want.sat) report("saturated", 0, m_saturated, want.sat);
                if (want.sat) n_sat++;
            end
            n_results++;
        end
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d results outstanding", rotated_q.size());
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        word_t comp[9];
        word_t zero9[9];
        int burst;
        zero9 = '{default: 0};
        rot_rows = '{ROW0_RST, ROW1_RST, ROW2_RST};

        // identity rotation after reset: forms pass through, unknown command gives zeros
        dir_tab[0]  = '{CMD_VEC, '{default: 0}, 1'b1, '{default: 0}};
        dir_tab[1]  = '{CMD_VEC, '{WMAX, WMIN, 1, 32'h5a5a5a5a, -7, WMAX, WMIN, 3, -1},
                        1'b1, '{WMAX, WMIN, 1, 0, 0, 0, 0, 0, 0}};
        dir_tab[2]  = '{CMD_VEC, '{WMIN, WMAX, -1, 0, 0, 0, 0, 0, 0},
                        1'b1, '{WMIN, WMAX, -1, 0, 0, 0, 0, 0, 0}};
        dir_tab[3]  = '{CMD_NONE, '{default: WMAX}, 1'b1, '{default: 0}};
        dir_tab[4]  = '{CMD_NONE, '{default: WMIN}, 1'b1, '{default: 0}};
        dir_tab[5]  = '{CMD_SYM, '{WMAX, WMIN, WMAX, WMIN, WMAX, WMIN, 5, 6, 7},
                        1'b1, '{WMAX, WMIN, WMAX, WMIN, WMAX, WMIN, 0, 0, 0}};
        dir_tab[6]  = '{CMD_SYM, '{default: -1}, 1'b1,
                        '{-1, -1, -1, -1, -1, -1, 0, 0, 0}};
        dir_tab[7]  = '{CMD_FULL, '{default: WMAX}, 1'b1, '{default: WMAX}};
        dir_tab[8]  = '{CMD_FULL, '{default: WMIN}, 1'b1, '{default: WMIN}};
        dir_tab[9]  = '{CMD_FULL, '{1, 2, 3, 4, 5, 6, 7, 8, 9}, 1'b1,
                        '{1, 2, 3, 4, 5, 6, 7, 8, 9}};
        dir_tab[10] = '{CMD_SYM, '{65536, -65536, 131072, 3, -3, 1, 0, 0, 0}, 1'b0,
                        '{default: 0}};
        dir_tab[11] = '{CMD_FULL, '{default: 32'h0001_0000}, 1'b0, '{default: 0}};

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_tab[i])
            send_item(dir_tab[i].cmd, dir_tab[i].comp, dir_tab[i].typed, dir_tab[i].res);

        burst = $urandom_range(1, 40);
        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: write_rows('0, '0, '0);
                1: write_rows({3{18'h1ffff}}, {3{18'h1ffff}}, {3{18'h1ffff}});
                2: write_rows({3{18'h20000}}, {3{18'h20000}}, {3{18'h20000}});
                default: write_rows(rand_row(), rand_row(), rand_row());
            endcase
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                for (int j = 0; j < 9; j++) comp[j] = rand_comp();
                send_item(($urandom_range(0, 15) == 0) ? CMD_NONE : 2'($urandom_range(0, 2)),
                          comp, 1'b0, zero9);
                if (--burst == 0) begin
                    s_valid <= 1'b0;
                    repeat ($urandom_range(1, 8)) @(posedge aclk);
                    burst = $urandom_range(1, 40);
                end
            end
        end

        s_valid <= 1'b0;
        while (rotated_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        $display("%0d items sent over %0d rotation settings plus reset identity",
                 n_items, N_PHASES);
        $display("%0d results checked, %0d of them clipped", n_results, n_sat);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches", errors);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
